>>> hdl/aalr_pkg.sv
// Shared constants, widths and controller/datapath interface types for the line rasterizer.
`default_nettype none

package aalr_pkg;

    localparam int FRAC_BITS  = 24;                          // slope / accumulator fraction
    localparam int COORD_BITS = 16;                          // endpoint coordinate width
    localparam int MAJ_W      = COORD_BITS + 1;              // major coordinate / extents
    localparam int ROW_W      = COORD_BITS + 2;              // minor coordinate incl. row + 1
    localparam int ACC_W      = COORD_BITS + FRAC_BITS + 2;  // running row accumulator
    localparam int SLOPE_W    = FRAC_BITS + 2;               // signed slope
    localparam int DIV_W      = COORD_BITS + FRAC_BITS;      // dividend / quotient shifter
    localparam int CNT_W      = $clog2(DIV_W + 1);
    localparam int PIX_W      = 12;
    localparam int COV_W      = 9;
    localparam int COV_FRAC_W = 8;
    localparam int CANVAS_W   = 13;
    localparam int IN_W       = 4 * COORD_BITS;
    localparam int OUT_W      = 40;

    localparam logic [CANVAS_W-1:0] CANVAS_CAP = 13'd4096;
    localparam logic [CANVAS_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CANVAS_W-1:0] HEIGHT_RST = 13'd480;

    localparam logic [COV_W-1:0] COV_FULL = 9'd256;
    localparam logic [COV_W-1:0] COV_HALF = 9'd128;
    localparam logic [COV_W-1:0] COV_NONE = 9'd0;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic cap;         // latch request payload
        logic prep;        // axis swap and endpoint ordering
        logic zero_load;   // single full-coverage pixel
        logic div_init;    // load divider
        logic div_step;    // one quotient bit
        logic slope_load;  // slope, accumulator, first endpoint pair
        logic end_load;    // second endpoint pair
        logic int_load;    // interior column pair, advance accumulator
        logic out_load;    // write output register
        logic out_sel_b;   // 0: first pixel of pair, 1: second
        logic out_last;    // tlast for the loaded pixel
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic zero_len;
        logic end_done;    // current column already at final column
        logic int_done;    // current column + 1 reaches final column
        logic keep_a;
        logic keep_b;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/aalr_dp.sv
// Datapath: endpoint setup, restoring slope divider, row accumulator, clipping, output register.
`default_nettype none

module aalr_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [aalr_pkg::IN_W-1:0]      i_s_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [aalr_pkg::CANVAS_W-1:0]  i_cfg_data,
    input  wire aalr_pkg::t_dp_cmd              i_cmd,
    output aalr_pkg::t_dp_sts                   o_sts,
    input  wire logic                           i_m_tready,
    output logic                                o_m_tvalid,
    output logic [aalr_pkg::OUT_W-1:0]          o_m_tdata,
    output logic                                o_m_tlast
);
    import aalr_pkg::*;

    // configuration
    logic [CANVAS_W-1:0] r_width, r_height;
    logic [CANVAS_W-1:0] w_wl, w_hl;

    // captured endpoints
    logic signed [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;

    // ordered endpoints (major a, minor b)
    logic                         r_steep;
    logic signed [COORD_BITS-1:0] r_a0, r_b0, r_a1, r_b1;

    // divider
    logic [COORD_BITS-1:0] r_dx, r_rem;
    logic                  r_neg;
    logic [DIV_W-1:0]      r_shift;

    // stepping state
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [MAJ_W-1:0]   r_cur;

    // pixel pair
    logic signed [MAJ_W-1:0] r_pmaj;
    logic signed [ROW_W-1:0] r_pmin;
    logic [COV_W-1:0]        r_pcov_a, r_pcov_b;
    logic                    r_single;

    // output register
    logic             r_ov, r_olast;
    logic [OUT_W-1:0] r_odata;

    // setup logic
    logic signed [MAJ_W-1:0] w_dx, w_dy, w_dxo, w_dyo;
    logic [MAJ_W-1:0]        w_adx, w_ady, w_adyo;
    logic                    w_steep;
    logic signed [COORD_BITS-1:0] w_m0, w_n0, w_m1, w_n1;
    logic [DIV_W-1:0]        w_dividend;

    // divider step
    logic [COORD_BITS:0] w_trial, w_diff;
    logic                w_ge;

    logic signed [SLOPE_W-1:0] w_slope;
    logic [SLOPE_W-2:0]        w_mag;
    logic [COV_FRAC_W-1:0]     w_frac;
    logic signed [ROW_W-1:0]   w_cur_p1, w_fcol;

    // clipping
    logic signed [ROW_W-1:0] w_maj, w_min_b;
    logic signed [ROW_W-1:0] w_px_a, w_py_a, w_px_b, w_py_b;

    function automatic logic f_on_canvas(
        input logic signed [ROW_W-1:0] px,
        input logic signed [ROW_W-1:0] py,
        input logic [CANVAS_W-1:0]     wl,
        input logic [CANVAS_W-1:0]     hl
    );
        f_on_canvas = !px[ROW_W-1] && !py[ROW_W-1] &&
                      (px < $signed(ROW_W'(wl))) && (py < $signed(ROW_W'(hl)));
    endfunction

    assign w_wl = (r_width  > CANVAS_CAP) ? CANVAS_CAP : r_width;
    assign w_hl = (r_height > CANVAS_CAP) ? CANVAS_CAP : r_height;

    always_comb begin
        w_dx    = MAJ_W'(r_x1) - MAJ_W'(r_x0);
        w_dy    = MAJ_W'(r_y1) - MAJ_W'(r_y0);
        w_adx   = w_dx[MAJ_W-1] ? MAJ_W'(-w_dx) : MAJ_W'(w_dx);
        w_ady   = w_dy[MAJ_W-1] ? MAJ_W'(-w_dy) : MAJ_W'(w_dy);
        w_steep = w_ady > w_adx;
        w_m0 = w_steep ? r_y0 : r_x0;
        w_n0 = w_steep ? r_x0 : r_y0;
        w_m1 = w_steep ? r_y1 : r_x1;
        w_n1 = w_steep ? r_x1 : r_y1;
        // extents of the ordered line
        w_dxo  = MAJ_W'(r_a1) - MAJ_W'(r_a0);
        w_dyo  = MAJ_W'(r_b1) - MAJ_W'(r_b0);
        w_adyo = w_dyo[MAJ_W-1] ? MAJ_W'(-w_dyo) : MAJ_W'(w_dyo);
        // |dy| * 2^F + dx / 2, rounded-to-nearest quotient
        w_dividend = {w_adyo[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}
                   + DIV_W'(w_dxo[COORD_BITS-1:1]);
    end

    always_comb begin
        w_trial = {r_rem, r_shift[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dx};
        w_ge    = w_trial >= {1'b0, r_dx};
    end

    always_comb begin
        w_mag    = r_shift[SLOPE_W-2:0];
        w_slope  = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        w_frac   = r_acc[FRAC_BITS-1 -: COV_FRAC_W];
        w_cur_p1 = ROW_W'(r_cur) + ROW_W'(1);
        w_fcol   = ROW_W'(r_a1);
    end

    always_comb begin
        w_maj   = ROW_W'(r_pmaj);
        w_min_b = r_pmin + ROW_W'(1);
        w_px_a  = r_steep ? r_pmin : w_maj;
        w_py_a  = r_steep ? w_maj  : r_pmin;
        w_px_b  = r_steep ? w_min_b : w_maj;
        w_py_b  = r_steep ? w_maj   : w_min_b;
    end

    always_comb begin
        o_sts.zero_len = (r_x0 == r_x1) && (r_y0 == r_y1);
        o_sts.end_done = r_cur >= MAJ_W'(r_a1);
        o_sts.int_done = w_cur_p1 >= w_fcol;
        o_sts.keep_a   = f_on_canvas(w_px_a, w_py_a, w_wl, w_hl);
        o_sts.keep_b   = f_on_canvas(w_px_b, w_py_b, w_wl, w_hl) && !r_single;
        o_sts.out_free = !r_ov || i_m_tready;
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) begin
                    r_width <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_x0 <= i_s_tdata[0*COORD_BITS +: COORD_BITS];
            r_y0 <= i_s_tdata[1*COORD_BITS +: COORD_BITS];
            r_x1 <= i_s_tdata[2*COORD_BITS +: COORD_BITS];
            r_y1 <= i_s_tdata[3*COORD_BITS +: COORD_BITS];
        end
        if (i_cmd.prep) begin
            r_steep <= w_steep;
            if (w_m0 > w_m1) begin
                r_a0 <= w_m1; r_b0 <= w_n1; r_a1 <= w_m0; r_b1 <= w_n0;
            end else begin
                r_a0 <= w_m0; r_b0 <= w_n0; r_a1 <= w_m1; r_b1 <= w_n1;
            end
        end
        if (i_cmd.div_init) begin
            r_dx    <= w_dxo[COORD_BITS-1:0];
            r_neg   <= w_dyo[MAJ_W-1];
            r_rem   <= '0;
            r_shift <= w_dividend;
        end
        if (i_cmd.div_step) begin
            r_rem   <= w_ge ? w_diff[COORD_BITS-1:0] : w_trial[COORD_BITS-1:0];
            r_shift <= {r_shift[DIV_W-2:0], w_ge};
        end
        if (i_cmd.zero_load) begin
            r_steep  <= 1'b0;
            r_pmaj   <= MAJ_W'(r_x0);
            r_pmin   <= ROW_W'(r_y0);
            r_pcov_a <= COV_FULL;
            r_pcov_b <= COV_NONE;
            r_single <= 1'b1;
        end
        if (i_cmd.slope_load) begin
            r_slope  <= w_slope;
            r_acc    <= $signed({(ACC_W-FRAC_BITS)'(r_b0), {FRAC_BITS{1'b0}}})
                      + ACC_W'(w_slope);
            r_cur    <= MAJ_W'(r_a0) + MAJ_W'(1);
            r_pmaj   <= MAJ_W'(r_a0);
            r_pmin   <= ROW_W'(r_b0);
            r_pcov_a <= COV_HALF;
            r_pcov_b <= COV_NONE;
            r_single <= 1'b0;
        end
        if (i_cmd.end_load) begin
            r_pmaj   <= MAJ_W'(r_a1);
            r_pmin   <= ROW_W'(r_b1);
            r_pcov_a <= COV_HALF;
            r_pcov_b <= COV_NONE;
            r_single <= 1'b0;
        end
        if (i_cmd.int_load) begin
            r_pmaj   <= r_cur;
            r_pmin   <= r_acc[ACC_W-1:FRAC_BITS];   // floor of the row
            r_pcov_a <= COV_FULL - COV_W'(w_frac);
            r_pcov_b <= COV_W'(w_frac);
            r_single <= 1'b0;
            r_acc    <= r_acc + ACC_W'(r_slope);
            r_cur    <= r_cur + MAJ_W'(1);
        end
        if (i_cmd.out_load) begin
            r_olast <= i_cmd.out_last;
            if (i_cmd.out_sel_b) begin
                r_odata <= {(OUT_W-2*PIX_W-COV_W)'(0), r_pcov_b,
                            w_py_b[PIX_W-1:0], w_px_b[PIX_W-1:0]};
            end else begin
                r_odata <= {(OUT_W-2*PIX_W-COV_W)'(0), r_pcov_a,
                            w_py_a[PIX_W-1:0], w_px_a[PIX_W-1:0]};
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire

>>> hdl/aalr_ctrl.sv
// Controller: sequences setup, slope division, pair loading and pixel emission.
`default_nettype none

module aalr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    input  wire logic          i_s_tuser,
    output logic               o_s_tready,
    input  wire aalr_pkg::t_dp_sts i_sts,
    output aalr_pkg::t_dp_cmd  o_cmd
);
    import aalr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_DIVI  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_SLOPE = 4'd4;
    localparam logic [3:0] S_PEND  = 4'd5;
    localparam logic [3:0] S_PINT  = 4'd6;
    localparam logic [3:0] S_EMA   = 4'd7;
    localparam logic [3:0] S_EMB   = 4'd8;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_END  = 2'd1;
    localparam logic [1:0] PH_INT  = 2'd2;

    logic [3:0]       r_state, n_state;
    logic             r_busy, n_busy;
    logic [1:0]       r_phase, n_phase;
    logic             r_fin, n_fin;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_busy     = r_busy;
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_s_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    if (i_s_tuser == FUNC_START) begin
                        n_busy  = 1'b0;
                        n_phase = PH_IDLE;
                        n_state = S_PREP;
                    end else if (r_busy) begin
                        n_state = (r_phase == PH_END) ? S_PEND : S_PINT;
                    end
                end
            end
            S_PREP: begin
                if (i_sts.zero_len) begin
                    o_cmd.zero_load = 1'b1;
                    n_fin   = 1'b1;
                    n_state = S_EMA;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = S_SLOPE;
                end
            end
            S_SLOPE: begin
                o_cmd.slope_load = 1'b1;
                n_busy  = 1'b1;
                n_phase = PH_END;
                n_fin   = 1'b0;
                n_state = S_EMA;
            end
            S_PEND: begin
                o_cmd.end_load = 1'b1;
                n_fin = i_sts.end_done;
                if (i_sts.end_done) begin
                    n_busy  = 1'b0;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_INT;
                end
                n_state = S_EMA;
            end
            S_PINT: begin
                o_cmd.int_load = 1'b1;
                n_fin = i_sts.int_done;
                if (i_sts.int_done) begin
                    n_busy  = 1'b0;
                    n_phase = PH_IDLE;
                end
                n_state = S_EMA;
            end
            S_EMA: begin
                if (!i_sts.keep_a) begin
                    n_state = S_EMB;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel_b = 1'b0;
                    o_cmd.out_last  = r_fin && !i_sts.keep_b;
                    n_state = S_EMB;
                end
            end
            S_EMB: begin
                if (!i_sts.keep_b) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel_b = 1'b1;
                    o_cmd.out_last  = r_fin;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_phase <= PH_IDLE;
            r_fin   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_fin   <= n_fin;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hdl/antialiased_line_rasterizer_top.sv
// Top level of the antialiased line rasterizer: controller plus datapath.
//
// Usage:
//  Input stream (i_s_*): tuser selects the request kind, 0 starts a new line
//  from the endpoints in tdata, 1 advances the current line by one step.
//  A start emits the first endpoint pair (or one full-coverage pixel for
//  a zero-length line); the first step emits the second endpoint pair,
//  each later one an interior column pair. Off-canvas pixels are dropped.
//  Output stream (o_m_*): one pixel per transfer, tlast marks the final
//  pixel of a line. Coverage is in 1/256 units for a downstream blender.
//  Config port: write canvas width / height (index 0 / 1) while idle.
// Timing:
//  The block holds one request at a time. A start runs capture, setup, a
//  restoring divider for the slope (one quotient bit per cycle) and slope
//  load (both skipped for a zero-length line), then the emit states; a step
//  runs capture, pair load, emit states. Clipped pixels skip their slot.
// Reset: synchronous, active low; the line is dropped, canvas returns to
//  640 x 480. A stalled receiver holds the block in its emit state; the
//  output register keeps the pending pixel until tready.
`default_nettype none

module antialiased_line_rasterizer_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
    input  wire logic [aalr_pkg::IN_W-1:0]     i_s_tdata,
    // tuser: func (0 = start, 1 = step)
    input  wire logic                          i_s_tuser,
    // pixel channel
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // tdata: pixel_x[11:0], pixel_y[23:12], coverage[32:24], zero[39:33]
    output logic [aalr_pkg::OUT_W-1:0]         o_m_tdata,
    output logic                               o_m_tlast,   // line_last
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [aalr_pkg::CANVAS_W-1:0] i_cfg_data
);
    import aalr_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    aalr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    aalr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
